FILE: rtl/ffcm_pkg.sv
package ffcm_pkg;

  localparam int unsigned ROW_W    = 32;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned CHECK_W  = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [16:0] FOLD_MODULUS = 17'd65535;
  localparam int unsigned HIGH_SHIFT   = 16;

  typedef enum logic {
    REG_WAIT_MODE = 1'b0,
    REG_EXPECTED  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                  wait_mode;
    logic [CHECK_W-1:0]    expected;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic                  close;
    logic                  last;
    logic [ROW_W-1:0]      plain;
    logic [ROW_W-1:0]      weighted;
  } row_fold_t;

  // (acc + add) mod 65535 by end-around folding of the 33-bit total
  function automatic logic [FRAME_W-1:0] fold_mod(input logic [FRAME_W-1:0] acc,
                                                   input logic [ROW_W-1:0] add);
    logic [32:0] total;
    logic [17:0] part;
    logic [16:0] near;
    total = {17'b0, acc} + {1'b0, add};
    part  = {1'b0, total[32:16]} + {2'b0, total[15:0]};
    near  = {1'b0, part[15:0]} + {15'b0, part[17:16]};
    if (near >= FOLD_MODULUS) begin
      near = near - FOLD_MODULUS;
    end
    return near[FRAME_W-1:0];
  endfunction

endpackage

FILE: rtl/frame_fletcher_checksum_match_top.sv
// frame checksum checker, fletcher style with two 16-bit sums modulo 65535
// input channel: pixel, row_end, frame_end with in_valid / in_stall; a transfer
// happens on a rising edge with in_valid high and in_stall low, one byte per
// transfer in raster order; frame_end also closes the current row
// output channel: checksum and matched with out_valid / out_stall, one result
// per frame, raised for the byte that carries frame_end
// the frame-end byte is held in row_out, then folded into the output register
// throughput: one byte per cycle while in_stall is low, through the pipelined
// row accumulate and frame fold stages
// when the receiver stalls, the result is held in the output register; bytes
// are still taken until a further frame end reaches the fold stage, which then
// waits for the pending result to be taken
// configuration: apb write at 0x0 sets wait_mode, at 0x4 expected_checksum;
// reads return the register, pready is tied high
// reset (rst, synchronous): all sums, valid flags and config registers clear
module frame_fletcher_checksum_match_top
  import ffcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic               row_end,
  input  logic               frame_end,
  input  logic               in_valid,
  output logic               in_stall,
  output logic [CHECK_W-1:0] checksum,
  output logic               matched,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t      cfg;
  row_fold_t row_fold;
  logic      fold_ready;

  ffcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffcm_row_acc u_row_acc (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .row_end    (row_end),
    .frame_end  (frame_end),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .fold_ready (fold_ready),
    .row_out    (row_fold)
  );

  ffcm_frame_fold u_frame_fold (
    .clk        (clk),
    .rst        (rst),
    .row_in     (row_fold),
    .cfg        (cfg),
    .fold_ready (fold_ready),
    .checksum   (checksum),
    .matched    (matched),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

FILE: rtl/ffcm_cfg.sv
module ffcm_cfg
  import ffcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_mode <= 1'b0;
      cfg.expected  <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_WAIT_MODE: cfg.wait_mode <= pwdata[0];
        REG_EXPECTED:  cfg.expected  <= pwdata[CHECK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_WAIT_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg.wait_mode};
      REG_EXPECTED:  prdata = cfg.expected;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ffcm_row_acc.sv
module ffcm_row_acc
  import ffcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic               row_end,
  input  logic               frame_end,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               fold_ready,
  output row_fold_t          row_out
);

  logic [ROW_W-1:0] row_sum;
  logic [ROW_W-1:0] row_weighted;
  logic [ROW_W-1:0] row_sum_next;
  logic [ROW_W-1:0] row_weighted_next;
  logic             accept;
  logic             close;

  assign in_stall          = !fold_ready;
  assign accept            = in_valid && fold_ready;
  assign close             = row_end || frame_end;
  assign row_sum_next      = row_sum + {{(ROW_W-PIXEL_W){1'b0}}, pixel};
  assign row_weighted_next = row_weighted + row_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum       <= '0;
      row_weighted  <= '0;
      row_out.valid <= 1'b0;
    end else begin
      if (accept) begin
        row_sum          <= close ? '0 : row_sum_next;
        row_weighted     <= close ? '0 : row_weighted_next;
        row_out.close    <= close;
        row_out.last     <= frame_end;
        row_out.plain    <= row_sum_next;
        row_out.weighted <= row_weighted_next;
      end
      if (fold_ready) begin
        row_out.valid <= accept;
      end
    end
  end

  // a closing byte leaves the row clear for the next one
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && close) |=> (row_sum == '0 && row_weighted == '0))
    else $error("row sums not cleared after row end");

endmodule

FILE: rtl/ffcm_frame_fold.sv
module ffcm_frame_fold
  import ffcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  row_fold_t          row_in,
  input  cfg_t               cfg,
  output logic               fold_ready,
  output logic [CHECK_W-1:0] checksum,
  output logic               matched,
  output logic               out_valid,
  input  logic               out_stall
);

  logic [FRAME_W-1:0] frame_plain;
  logic [FRAME_W-1:0] frame_weighted;
  logic [FRAME_W-1:0] frame_plain_next;
  logic [FRAME_W-1:0] frame_weighted_next;
  logic [CHECK_W-1:0] checksum_next;
  logic               take;

  // a frame end may only move on when the result slot frees up
  assign fold_ready = !row_in.valid || !row_in.last || !out_valid || !out_stall;
  assign take       = row_in.valid && fold_ready;

  assign frame_plain_next    = fold_mod(frame_plain, row_in.plain);
  assign frame_weighted_next = fold_mod(frame_weighted, row_in.weighted);
  assign checksum_next       = ({{(CHECK_W-FRAME_W){1'b0}}, frame_weighted_next} << HIGH_SHIFT)
                             | {{(CHECK_W-FRAME_W){1'b0}}, frame_plain_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_plain    <= '0;
      frame_weighted <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take && (row_in.close || row_in.last)) begin
        frame_plain    <= row_in.last ? '0 : frame_plain_next;
        frame_weighted <= row_in.last ? '0 : frame_weighted_next;
      end
      if (take && row_in.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && row_in.last) begin
      checksum <= checksum_next;
      matched  <= cfg.wait_mode ? (checksum_next == cfg.expected) : 1'b1;
    end
  end

  a_below_modulus: assert property (@(posedge clk) disable iff (rst)
    (frame_plain != 16'hFFFF) && (frame_weighted != 16'hFFFF))
    else $error("frame sum reached the modulus");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (take && row_in.last) |=> (frame_plain == '0 && frame_weighted == '0 && out_valid))
    else $error("frame end did not clear sums or raise a result");

  a_match_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cfg.wait_mode) |-> matched)
    else $error("mismatch reported outside wait mode");

endmodule

FILE: test/frame_fletcher_checksum_match_top_test.sv
`timescale 1ns / 1ps

module frame_fletcher_checksum_match_top_test
  import ffcm_pkg::*;
();

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 1200;
  localparam int DEEP_LEN     = 5900;
  localparam int DRILL_ROWS   = 18;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
  } beat_t;

  typedef struct packed {
    logic [CHECK_W-1:0] checksum;
    logic               matched;
  } frame_result_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_total;
    logic [ROW_W-1:0]   row_ramp;
    logic [FRAME_W-1:0] frame_plain;
    logic [FRAME_W-1:0] frame_ramp;
  } sums_t;

  typedef struct packed {
    logic               cfg_now;
    logic               cfg_wait;
    logic [CHECK_W-1:0] cfg_expected;
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
    logic               known;
    logic [CHECK_W-1:0] known_checksum;
    logic               known_matched;
  } drill_row_t;

  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{1'b1, 1'b0, 32'h0000_0000, 8'd0,   1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd255, 1'b1, 1'b1, 1'b1, 32'h00FF_00FF, 1'b1},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd255, 1'b0, 1'b1, 1'b1, 32'h00FF_00FF, 1'b1},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd1,   1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd2,   1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd3,   1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd4,   1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd128, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd127, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b1, 1'b1, 32'h00FF_00FF, 8'd255, 1'b1, 1'b1, 1'b1, 32'h00FF_00FF, 1'b1},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd254, 1'b1, 1'b1, 1'b1, 32'h00FE_00FE, 1'b0},
    '{1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0,   1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b1, 1'b1, 32'h0000_0000, 8'd0,   1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd1,   1'b1, 1'b1, 1'b1, 32'h0001_0001, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd0,   1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b1, 1'b0, 32'h1234_5678, 8'd200, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd55,  1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 1'b0, 32'h0000_0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic [PIXEL_W-1:0] pixel;
  logic               row_end;
  logic               frame_end;
  logic               in_valid;
  logic               in_stall;
  logic [CHECK_W-1:0] checksum;
  logic               matched;
  logic               out_valid;
  logic               out_stall;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  frame_result_t      results_due[$];
  beat_t              frame_beats[$];
  beat_t              anchor_beats[$];
  sums_t              live_sums = '0;
  logic               cfg_wait = 1'b0;
  logic [CHECK_W-1:0] cfg_expected = '0;
  bit                 steady = 1'b0;
  bit                 hold_due = 1'b0;
  int                 fail_count = 0;
  int                 idle_cycles = 0;

  frame_fletcher_checksum_match_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .row_end   (row_end),
    .frame_end (frame_end),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .checksum  (checksum),
    .matched   (matched),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [FRAME_W-1:0] mod_fold(input logic [FRAME_W-1:0] acc,
                                                  input logic [ROW_W-1:0] add);
    longint unsigned total;
    total = longint'(acc) + longint'(add);
    return FRAME_W'(total % 65535);
  endfunction

  // returns 1 when the byte closes a frame, with the frame checksum in sum
  function automatic bit absorb_byte(inout sums_t s, input beat_t b,
                                     output logic [CHECK_W-1:0] sum);
    sum = '0;
    s.row_total = s.row_total + ROW_W'(b.pixel);
    s.row_ramp  = s.row_ramp + s.row_total;
    if (!b.row_end && !b.frame_end) begin
      return 1'b0;
    end
    s.frame_plain = mod_fold(s.frame_plain, s.row_total);
    s.frame_ramp  = mod_fold(s.frame_ramp, s.row_ramp);
    s.row_total   = '0;
    s.row_ramp    = '0;
    if (!b.frame_end) begin
      return 1'b0;
    end
    sum = {s.frame_ramp, s.frame_plain};
    s.frame_plain = '0;
    s.frame_ramp  = '0;
    return 1'b1;
  endfunction

  function automatic logic [CHECK_W-1:0] frame_checksum(input beat_t f[$]);
    sums_t              s;
    logic [CHECK_W-1:0] sum;
    logic [CHECK_W-1:0] last_sum;
    s = '0;
    last_sum = '0;
    foreach (f[i]) begin
      if (absorb_byte(s, f[i], sum)) begin
        last_sum = sum;
      end
    end
    return last_sum;
  endfunction

  task automatic plan_frame(output beat_t f[$]);
    int    rows;
    int    len;
    beat_t b;
    f = {};
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 400) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        b.pixel     = PIXEL_W'($urandom_range(0, 255));
        b.row_end   = (i == len - 1);
        b.frame_end = 1'b0;
        f = {f, b};
      end
    end
    b = f[f.size() - 1];
    b.frame_end = 1'b1;
    b.row_end   = ($urandom_range(0, 3) != 0);
    f[f.size() - 1] = b;
  endtask

  // short full row, then a long row whose weighted sum lands just under 2^32,
  // so the weighted fold overflows 32 bits
  task automatic plan_deep_frame(output beat_t f[$]);
    longint unsigned surplus;
    longint unsigned cut;
    beat_t           b;
    f = {};
    for (int i = 0; i < 22; i++) begin
      b.pixel     = 8'd255;
      b.row_end   = (i == 21);
      b.frame_end = 1'b0;
      f = {f, b};
    end
    surplus = longint'(255) * DEEP_LEN * (DEEP_LEN + 1) / 2
              - ((longint'(1) << 32) - $urandom_range(1, 64000));
    for (int j = 0; j < DEEP_LEN; j++) begin
      cut = surplus / (DEEP_LEN - j);
      if (cut > 255) begin
        cut = 255;
      end
      surplus = surplus - cut * (DEEP_LEN - j);
      b.pixel     = PIXEL_W'(255 - cut);
      b.row_end   = (j == DEEP_LEN - 1);
      b.frame_end = (j == DEEP_LEN - 1);
      f = {f, b};
    end
  endtask

  task automatic offer_byte(input beat_t b, input bit known, input frame_result_t known_res);
    int                 gap;
    logic [CHECK_W-1:0] sum;
    frame_result_t      due;
    gap = steady ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    pixel     <= b.pixel;
    row_end   <= b.row_end;
    frame_end <= b.frame_end;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (absorb_byte(live_sums, b, sum)) begin
      due.checksum = sum;
      due.matched  = cfg_wait ? (sum == cfg_expected) : 1'b1;
      results_due = {results_due, (known ? known_res : due)};
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic wait_on, input logic [CHECK_W-1:0] expected);
    settle();
    write_reg(REG_WAIT_MODE, DATA_W'(wait_on));
    write_reg(REG_EXPECTED, DATA_W'(expected));
    cfg_wait     = wait_on;
    cfg_expected = expected;
  endtask

  // receiving side
  initial begin
    int            hold;
    frame_result_t want;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 7);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (results_due.size() == 0) begin
        $error("checksum result with no frame pending: checksum %h matched %b",
               checksum, matched);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (checksum !== want.checksum) begin
          $error("checksum: expected %h, got %h", want.checksum, checksum);
          fail_count++;
        end
        if (matched !== want.matched) begin
          $error("matched: expected %b, got %b", want.matched, matched);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("frame_fletcher_checksum_match_top_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 phase;
    int                 random_bytes;
    int                 frames;
    bit                 deep;
    logic               wait_on;
    logic [CHECK_W-1:0] expected;
    drill_row_t         row;
    beat_t              b;
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel     = '0;
    row_end   = 1'b0;
    frame_end = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DRILL_ROWS; i++) begin
      row = DRILL[i];
      if (row.cfg_now) begin
        set_config(row.cfg_wait, row.cfg_expected);
      end
      b = '{row.pixel, row.row_end, row.frame_end};
      offer_byte(b, row.known, '{row.known_checksum, row.known_matched});
    end

    phase = 0;
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      wait_on = (phase % 3 != 0);
      plan_frame(anchor_beats);
      expected = ($urandom_range(0, 3) == 0) ? $urandom() : frame_checksum(anchor_beats);
      set_config(wait_on, expected);
      if (phase == 0 || phase == 2) begin
        hold_due = 1'b1;
      end
      frames = $urandom_range(3, 10);
      for (int f = 0; f < frames; f++) begin
        steady = ($urandom_range(0, 4) == 0);
        deep = (phase == 0 && f == 0);
        if (deep) begin
          plan_deep_frame(frame_beats);
        end else if (wait_on && $urandom_range(0, 1) == 1) begin
          frame_beats = anchor_beats;
        end else begin
          plan_frame(frame_beats);
        end
        foreach (frame_beats[i]) begin
          offer_byte(frame_beats[i], 1'b0, '0);
        end
        if (!deep) begin
          random_bytes += frame_beats.size();
        end
      end
      steady = 1'b0;
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("frame_fletcher_checksum_match_top_test: done, clean");
    end else begin
      $display("frame_fletcher_checksum_match_top_test: done, errors");
    end
    $finish;
  end

endmodule
